>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MBPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MBPS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/mbps_pkg.sv
// Types and constants of the masked byte pattern scanner.
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int PAT_MAX   = 16;
    localparam int WIN_IDX_W = $clog2(PAT_MAX);
    localparam int LEN_W     = 5;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = Q_PTR_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WC_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIM  = 3'd4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [63:0] byte_address;
        logic        region_start;
        logic        scan_start;
    } t_in_item;

    typedef struct packed {
        logic [63:0] hit_address;
        logic        limit_reached;
    } t_out_item;

    typedef struct packed {
        logic [63:0] pattern_bytes_low;
        logic [63:0] pattern_bytes_high;
        logic [15:0] wildcard_mask;
        logic [4:0]  pattern_length;
        logic [31:0] hit_limit;
    } t_cfg;

    // Classified item passed from the front to the back.
    typedef struct packed {
        logic [63:0]          byte_address;
        logic [WIN_IDX_W-1:0] len_m1;
        logic                 is_match;
        logic                 scan_start;
    } t_cls_item;

endpackage

>>> hdl/mbps_queue.sv
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps

module mbps_queue import mbps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_item i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_cls_item o_data
);

    t_cls_item          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hdl/mbps_front.sv
// Front: accepts items, keeps the byte window and classifies each item as match or not.
`timescale 1ns / 1ps

module mbps_front import mbps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    input  logic      i_full,
    output logic      o_push,
    output t_cls_item o_cls
);

    logic [7:0]           r_win [PAT_MAX];
    logic [WIN_IDX_W-1:0] r_fill;
    logic [WIN_IDX_W-1:0] n_fill;

    logic                 accept;
    logic [LEN_W-1:0]     len_c;
    logic [WIN_IDX_W-1:0] fill_eff;
    logic [127:0]         pattern;
    logic [LEN_W-1:0]     idx_full [PAT_MAX];
    logic [7:0]           cand [PAT_MAX];
    logic [PAT_MAX-1:0]   fixed;
    logic [PAT_MAX-1:0]   diff;
    logic                 fill_ok;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept;

    assign len_c    = (i_cfg.pattern_length > LEN_W'(PAT_MAX)) ? LEN_W'(PAT_MAX)
                                                               : i_cfg.pattern_length;
    assign fill_eff = i_item.region_start ? '0 : r_fill;
    assign pattern  = {i_cfg.pattern_bytes_high, i_cfg.pattern_bytes_low};
    assign fill_ok  = (LEN_W'(fill_eff) >= (len_c - LEN_W'(1)));

    // Pattern byte k lines up with the current byte for the last one, else
    // with the window entry len-2-k back.
    always_comb begin
        for (int k = 0; k < PAT_MAX; k++) begin
            idx_full[k] = len_c - LEN_W'(2) - LEN_W'(k);
            cand[k]     = (LEN_W'(k) == (len_c - LEN_W'(1))) ? i_item.data_byte
                                                             : r_win[idx_full[k][WIN_IDX_W-1:0]];
            fixed[k]    = (LEN_W'(k) < len_c) && !i_cfg.wildcard_mask[k];
            diff[k]     = fixed[k] && (cand[k] != pattern[8*k +: 8]);
        end
    end

    always_comb begin
        o_cls.byte_address = i_item.byte_address;
        o_cls.len_m1       = (len_c == '0) ? '0 : WIN_IDX_W'(len_c - LEN_W'(1));
        o_cls.is_match     = (len_c != '0) && fill_ok && (|fixed) && !(|diff);
        o_cls.scan_start   = i_item.scan_start;
    end

    assign n_fill = (fill_eff < WIN_IDX_W'(PAT_MAX - 1)) ? fill_eff + WIN_IDX_W'(1) : fill_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    // Shift the current byte in, most recent at entry 0.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win[0] <= i_item.data_byte;
            for (int i = 1; i < PAT_MAX; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

endmodule

>>> hdl/mbps_back.sv
// Back: counts hits per scan, applies the hit limit and holds the result register.
`timescale 1ns / 1ps

module mbps_back import mbps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_head_valid,
    input  t_cls_item i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic [31:0] r_count;
    logic        r_capped;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] n_count;
    logic        n_capped;
    logic [31:0] limit_eff;
    logic [31:0] count_eff;
    logic        capped_eff;
    logic [31:0] count_inc;
    logic        reach;
    logic        hit;
    logic        out_free;

    assign limit_eff  = (i_cfg.hit_limit == '0) ? 32'd1 : i_cfg.hit_limit;
    assign count_eff  = i_head.scan_start ? '0 : r_count;
    assign capped_eff = i_head.scan_start ? 1'b0 : r_capped;
    assign count_inc  = count_eff + 32'd1;
    assign reach      = (count_inc >= limit_eff);
    assign hit        = i_head.is_match && !capped_eff;
    assign out_free   = !r_out_valid || !i_stall;

    // Items without a hit drain even while the result register is held.
    assign o_pop    = i_head_valid && (out_free || !hit);
    assign n_count  = hit ? count_inc : count_eff;
    assign n_capped = capped_eff || (hit && reach);

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_capped    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count  <= n_count;
                r_capped <= n_capped;
            end
            if (o_pop && hit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && hit) begin
            r_out.hit_address   <= i_head.byte_address - 64'(i_head.len_m1);
            r_out.limit_reached <= reach;
        end
    end

endmodule

>>> hdl/masked_byte_pattern_scanner_top.sv
// Top level of the masked byte pattern scanner.
`timescale 1ns / 1ps
//
// Input channel: i_in_valid / o_in_stall carry one memory byte per item with
// its address and the region_start and scan_start marks. Output channel:
// o_out_valid / i_out_stall carry one hit per item: the start address of a
// match and the limit_reached flag. An item moves at an edge where valid is
// high and stall is low.
// Configuration: write i_cfg_wdata to register i_cfg_index at an edge with
// i_cfg_we high, while the block is idle (0 pattern low, 1 pattern high,
// 2 wildcard mask, 3 pattern length, 4 hit limit).
// With an empty queue, the accepted byte is written into the queue, then popped by
// the back into the output register, where o_out_valid rises. Throughput: one byte
// per cycle while o_in_stall is low, set by the combinational window compare in the
// front and the one-item-per-cycle drain of the back.
// A stalled output holds its hit; bytes without a hit keep draining, and the
// four-entry queue raises o_in_stall only once it fills behind a held hit.
// Reset empties the window, the queue and the output, zeroes the hit count
// and returns the registers to their reset values.

module masked_byte_pattern_scanner_top import mbps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    t_cfg      r_cfg;
    logic      push;
    logic      full;
    logic      pop;
    logic      head_valid;
    t_cls_item cls;
    t_cls_item head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes_low  <= '0;
            r_cfg.pattern_bytes_high <= '0;
            r_cfg.wildcard_mask      <= '0;
            r_cfg.pattern_length     <= 5'd1;
            r_cfg.hit_limit          <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAT_LOW:  r_cfg.pattern_bytes_low  <= i_cfg_wdata;
                CFG_PAT_HIGH: r_cfg.pattern_bytes_high <= i_cfg_wdata;
                CFG_WC_MASK:  r_cfg.wildcard_mask      <= i_cfg_wdata[15:0];
                CFG_PAT_LEN:  r_cfg.pattern_length     <= i_cfg_wdata[4:0];
                CFG_HIT_LIM:  r_cfg.hit_limit          <= i_cfg_wdata[31:0];
                default:      r_cfg                    <= r_cfg;
            endcase
        end
    end

    mbps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_full  (full),
        .o_push  (push),
        .o_cls   (cls)
    );

    mbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head)
    );

    mbps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_item       (o_out_item)
    );

endmodule

>>> hdl/mbps_checker.sv
// Port-level checker for the masked byte pattern scanner, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbps_checker import mbps_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `MBPS_ASSERT_RST(a_rst_out_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `MBPS_ASSERT_RST(a_rst_in_open, !i_rst_n |=> !o_in_stall, "input stalled after reset")
    `MBPS_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item), "stalled hit changed")
    // The queue only fills behind a held hit.
    `MBPS_ASSERT(a_stall_behind_hit, o_in_stall |-> o_out_valid, "input stalled with no hit held")

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (.*);

>>> tb/sv/masked_byte_pattern_scanner_top_tb.sv
// Self-checking testbench for the masked byte pattern scanner top level.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_top_tb import mbps_pkg::*; ();

    localparam int TOTAL_ITEMS    = 1450;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 60;

    // Mirrors the scanner: window, hit count, cap flag and register copies.
    class scan_hit_tracker;
        logic [127:0] pattern;
        logic [15:0]  wc_mask;
        logic [4:0]   pat_len;
        logic [31:0]  hit_lim;
        logic [7:0]   win [PAT_MAX-1];
        int           fill;
        logic [31:0]  hits;
        bit           capped;
        t_out_item    expected_hits [$];
        int           errors;

        function new();
            pattern = '0;
            wc_mask = '0;
            pat_len = 5'd1;
            hit_lim = '1;
            foreach (win[i]) win[i] = 8'h00;
            fill    = 0;
            hits    = '0;
            capped  = 1'b0;
            errors  = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_PAT_LOW:  pattern[63:0]   = val;
                CFG_PAT_HIGH: pattern[127:64] = val;
                CFG_WC_MASK:  wc_mask         = val[15:0];
                CFG_PAT_LEN:  pat_len         = val[4:0];
                CFG_HIT_LIM:  hit_lim         = val[31:0];
                default: ;
            endcase
        endfunction

        function void take_byte(t_in_item it);
            int          len;
            int          k;
            logic [31:0] lim;
            logic [7:0]  b;
            bit          any_fixed;
            bit          agree;
            t_out_item   hit;
            len = pat_len;
            if (len > PAT_MAX) len = PAT_MAX;
            lim = (hit_lim == 0) ? 32'd1 : hit_lim;
            if (it.region_start) begin
                foreach (win[i]) win[i] = 8'h00;
                fill = 0;
            end
            if (it.scan_start) begin
                hits   = '0;
                capped = 1'b0;
            end
            if (len > 0 && !capped && fill >= len - 1) begin
                any_fixed = 1'b0;
                agree     = 1'b1;
                for (k = 0; k < len; k++) begin
                    if (!wc_mask[k]) begin
                        any_fixed = 1'b1;
                        // the current byte closes the candidate
                        b = (k == len - 1) ? it.data_byte : win[len - 2 - k];
                        if (b != pattern[8*k +: 8]) agree = 1'b0;
                    end
                end
                if (any_fixed && agree) begin
                    hits              = hits + 32'd1;
                    hit.hit_address   = it.byte_address - 64'(len - 1);
                    hit.limit_reached = (hits >= lim);
                    if (hits >= lim) capped = 1'b1;
                    expected_hits.insert(expected_hits.size(), hit);
                end
            end
            for (k = PAT_MAX - 2; k > 0; k--) win[k] = win[k-1];
            win[0] = it.data_byte;
            if (fill < PAT_MAX - 1) fill++;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_hit(t_out_item got);
            t_out_item want;
            if (expected_hits.size() == 0) begin
                report_mismatch($sformatf("unexpected hit at %h", got.hit_address));
            end else begin
                want = expected_hits.pop_front();
                if (got.hit_address !== want.hit_address)
                    report_mismatch($sformatf("hit_address %h, want %h",
                                              got.hit_address, want.hit_address));
                if (got.limit_reached !== want.limit_reached)
                    report_mismatch($sformatf("limit_reached %b, want %b at %h",
                                              got.limit_reached, want.limit_reached,
                                              want.hit_address));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_item;

    scan_hit_tracker sb;
    int idle_pct;
    int stall_pct;
    int hold_left;
    int items_sent;
    int quiet_cycles;

    masked_byte_pattern_scanner_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: random stall, or a long hold-off when one is requested.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Note accepted bytes, check accepted hits, watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.take_byte(i_in_item);
            if (o_out_valid && !i_out_stall) sb.check_hit(o_out_item);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] data, input logic [63:0] addr,
                             input bit rs, input bit ss);
        t_in_item it;
        it.data_byte    = data;
        it.byte_address = addr;
        it.region_start = rs;
        it.scan_start   = ss;
        send_item(it);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_hits_drained();
        @(negedge i_clk);
        while (sb.expected_hits.size() > 0) @(negedge i_clk);
    endtask

    // Hold the input, let every hit out, then let bytes without a hit clear.
    task automatic quiesce();
        stop_sending();
        wait_hits_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        sb.apply_reg(idx, val);
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] msk, input logic [4:0] ln,
                              input logic [31:0] lim);
        write_cfg_reg(CFG_PAT_LOW, lo);
        write_cfg_reg(CFG_PAT_HIGH, hi);
        write_cfg_reg(CFG_WC_MASK, 64'(msk));
        write_cfg_reg(CFG_PAT_LEN, 64'(ln));
        write_cfg_reg(CFG_HIT_LIM, 64'(lim));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_config(input int ph);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] msk;
        logic [4:0]  ln;
        logic [31:0] lim;
        lo  = {$urandom, $urandom};
        hi  = {$urandom, $urandom};
        msk = 16'($urandom & $urandom);
        ln  = 5'($urandom_range(1, 8));
        lim = $urandom_range(1, 6);
        case ($urandom_range(9))
            0: ln  = 5'($urandom_range(9, 16));
            1: ln  = 5'($urandom_range(17, 31));
            2: ln  = 5'd0;
            3: msk = 16'h0000;
            4: lim = 32'd0;
            5: lim = '1;
            6: lim = $urandom;
            default: ;
        endcase
        case (ph)
            0: begin
                lo  = '1;
                hi  = '1;
                msk = 16'h0000;
                ln  = 5'd16;
                lim = '1;
            end
            1: begin
                ln  = 5'd31;
                msk = 16'h8001;
                lim = 32'd0;
            end
            2: ln  = 5'd0;
            4: begin
                msk = 16'hFFFF;
                ln  = 5'd8;
            end
            default: ;
        endcase
        set_config(lo, hi, msk, ln, lim);
    endtask

    // One region: planted pattern copies, near misses and noise bytes.
    task automatic send_region(input bit new_scan);
        logic [7:0]  bytes_q [$];
        logic [7:0]  b;
        logic [63:0] addr;
        int          nbytes;
        int          plen;
        int          k;
        bit          rs;
        bit          ss;
        plen = sb.pat_len;
        if (plen == 0) plen = 1;
        if (plen > PAT_MAX) plen = PAT_MAX;
        nbytes = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
        while (bytes_q.size() < nbytes) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    for (k = 0; k < plen; k++) begin
                        b = sb.pattern[8*k +: 8];
                        if (sb.wc_mask[k]) b = 8'($urandom_range(255));
                        if ($urandom_range(9) == 0) b = b ^ 8'(1 << $urandom_range(7));
                        bytes_q.insert(bytes_q.size(), b);
                    end
                end
                4, 5, 6: bytes_q.insert(bytes_q.size(),
                                        sb.pattern[8*$urandom_range(plen - 1) +: 8]);
                default: bytes_q.insert(bytes_q.size(), 8'($urandom_range(255)));
            endcase
        end
        case ($urandom_range(7))
            0: addr = 64'h0;
            1: addr = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(15));
            default: addr = {$urandom, $urandom};
        endcase
        foreach (bytes_q[i]) begin
            rs = (i == 0) && ($urandom_range(7) != 0);
            ss = ((i == 0) && new_scan) || ($urandom_range(47) == 0);
            send_byte(bytes_q[i], addr, rs, ss);
            addr = addr + 64'd1;
        end
    endtask

    initial begin
        int phase;
        int phase_start;
        int k;
        logic [63:0] a;

        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_left   = 0;
        items_sent  = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset config: one-byte pattern of zero, address extremes.
        send_byte(8'h00, 64'h0, 1'b1, 1'b1);
        send_byte(8'hFF, '1, 1'b0, 1'b0);
        send_byte(8'h00, '1, 1'b0, 1'b0);
        quiesce();

        // Four bytes, byte 1 wildcard, limit of two; hit address wraps.
        set_config(64'hFFFF_FFFF_4433_2211, '1, 16'h0002, 5'd4, 32'd2);
        a = 64'hFFFF_FFFF_FFFF_FFFE;
        send_byte(8'h11, a, 1'b1, 1'b1);
        send_byte(8'h99, a + 1, 1'b0, 1'b0);
        send_byte(8'h33, a + 2, 1'b0, 1'b0);
        send_byte(8'h44, a + 3, 1'b0, 1'b0);
        for (k = 0; k < 8; k++)
            send_byte(8'h11 * 8'((k % 4) + 1), a + 4 + k, 1'b0, 1'b0);
        // short region, then a new scan in a fresh region
        send_byte(8'h11, 64'h100, 1'b1, 1'b0);
        send_byte(8'h22, 64'h101, 1'b0, 1'b0);
        send_byte(8'h33, 64'h102, 1'b0, 1'b0);
        send_byte(8'h44, 64'h200, 1'b1, 1'b1);
        send_byte(8'h11, 64'h300, 1'b1, 1'b0);
        send_byte(8'h22, 64'h301, 1'b0, 1'b0);
        send_byte(8'h33, 64'h302, 1'b0, 1'b0);
        send_byte(8'h44, 64'h303, 1'b0, 1'b0);
        quiesce();

        set_config(64'hFFFF_FFFF_4433_2211, '1, 16'h0000, 5'd0, '1);
        send_byte(8'h11, 64'h400, 1'b0, 1'b1);
        quiesce();

        // limit of zero flags the first hit and caps the scan
        set_config(64'h11, 64'h0, 16'h0000, 5'd1, 32'd0);
        send_byte(8'h11, 64'h500, 1'b0, 1'b1);
        send_byte(8'h11, 64'h501, 1'b0, 1'b0);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            quiesce();
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            phase_start = items_sent;
            if (phase == 3) begin
                // hold the output while every byte hits, so the input backs up
                set_config(64'h5A, 64'h0, 16'h0000, 5'd1, '1);
                idle_pct  = 0;
                hold_left = HOLD_CYCLES;
                for (k = 0; k < 48; k++)
                    send_byte(8'h5A, 64'h1000 + 64'(k), k == 0, k == 0);
            end else begin
                random_config(phase);
                while (items_sent - phase_start < PHASE_ITEMS) begin
                    send_region($urandom_range(1));
                    if ($urandom_range(9) == 0) begin
                        stop_sending();
                        wait_hits_drained();
                    end
                end
            end
            phase++;
        end

        stop_sending();
        wait_hits_drained();
        repeat (SETTLE_CYCLES + 4) @(negedge i_clk);
        if (sb.expected_hits.size() != 0)
            sb.report_mismatch($sformatf("%0d hits never came", sb.expected_hits.size()));
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
